// File: rtl/ptna_pkg.sv
package ptna_pkg;

   localparam int COORD_W   = 32;
   localparam int FRAC_BITS = 16;
   localparam int BOX_W     = 31;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int MAG_W     = COORD_W;
   localparam int PROD_W    = 2 * MAG_W;
   localparam int SPROD_W   = PROD_W + 1;
   localparam int CROSS_W   = PROD_W + 2;
   localparam int CMAG_W    = CROSS_W - 1;
   localparam int MM_W      = 61;
   localparam int MM_LO_W   = 31;
   localparam int MM_HI_W   = MM_W - MM_LO_W;
   localparam int SQ_W      = 2 * MM_W;
   localparam int SUM_W     = SQ_W + 2;
   localparam int ROOT_W    = SUM_W / 2;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int DIV_STEPS = 30;
   localparam int QUOT_W    = DIV_STEPS + 1;
   localparam int REM_W     = ROOT_W;
   localparam int NORM_W    = 32;
   localparam int AREA_W    = 48;
   localparam int SHIFT_W   = 3;
   localparam int CSR_IDX_W = 2;
   localparam int FRONT_STAGES = 11;

   localparam logic [BOX_W-1:0] BOX_RESET = BOX_W'(655360);

   localparam logic [CSR_IDX_W-1:0] REG_BOX_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_Z = 2'd2;

   typedef struct packed {
      logic [SUM_W-1:0]         rad;
      logic [SUM_W-1:0]         root;
      logic [2:0][MM_W-1:0]     mm;
      logic [2:0]               neg;
      logic [SHIFT_W-1:0]       shift;
      logic                     degen;
   } sqrt_stage_type;

   typedef struct packed {
      logic [ROOT_W-1:0]        den;
      logic [2:0][REM_W-1:0]    rem;
      logic [2:0][QUOT_W-1:0]   quot;
      logic [2:0]               neg;
      logic [AREA_W-1:0]        area;
      logic                     degen;
   } div_stage_type;

endpackage

// File: rtl/periodic_triangle_normal_area.sv
// Unit normal and area of one triangle in a periodic box. Vertices arrive as signed
// Q16.16; both edges from the first vertex are folded by the minimum-image rule against
// the box sides in box_x/y/z (csr indexes 0..2, other indexes ignored). The exact cross
// product is reduced to at most 61 bits per component, its length comes from a square
// root, and each component is divided by that length into a Q2.30 normal. Area is half
// the length in Q32.16, saturated to 48 bits. A zero cross product gives degenerate=1 with
// zero normal and area. Rate: one triangle per clock. The pipeline holds 11 front
// stages (edges, wrap, 32x32 products, cross, scaling, squares), 63 for the sum and the
// one-bit-per-stage square root, 31 for the three bit-serial dividers in parallel, and the
// output register. A stalled result freezes the whole pipeline, and only then is req
// stalled; csr writes are always ready.
module periodic_triangle_normal_area (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [ptna_pkg::COORD_W-1:0] req_p1_x,
   input  logic signed [ptna_pkg::COORD_W-1:0] req_p1_y,
   input  logic signed [ptna_pkg::COORD_W-1:0] req_p1_z,
   input  logic signed [ptna_pkg::COORD_W-1:0] req_p2_x,
   input  logic signed [ptna_pkg::COORD_W-1:0] req_p2_y,
   input  logic signed [ptna_pkg::COORD_W-1:0] req_p2_z,
   input  logic signed [ptna_pkg::COORD_W-1:0] req_p3_x,
   input  logic signed [ptna_pkg::COORD_W-1:0] req_p3_y,
   input  logic signed [ptna_pkg::COORD_W-1:0] req_p3_z,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [ptna_pkg::NORM_W-1:0] rsp_normal_x,
   output logic signed [ptna_pkg::NORM_W-1:0] rsp_normal_y,
   output logic signed [ptna_pkg::NORM_W-1:0] rsp_normal_z,
   output logic [ptna_pkg::AREA_W-1:0]        rsp_tri_area,
   output logic                              rsp_degenerate,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ptna_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ptna_pkg::BOX_W-1:0]         csr_wdata
);
   import ptna_pkg::*;

   // config registers
   logic [2:0][BOX_W-1:0] box_ff;

   // pipeline advance: everything moves unless the output beat is held
   logic en;

   // front stages, edge index j: 0..2 = p2-p1 (x,y,z), 3..5 = p3-p1
   logic [FRONT_STAGES-1:0]       fv_ff, fv_in;
   logic [5:0][DIFF_W-1:0]        diff_ff, diff_in;   // s1 raw edge
   logic [5:0][DIFF_W-1:0]        dw_ff, dw_in;       // s2 edge, wrap flag
   logic [5:0]                    wrap_ff, wrap_in;
   logic [5:0][DIFF_W-1:0]        edge_ff, edge_in;   // s3 wrapped edge
   logic [5:0][MAG_W-1:0]         emag_ff, emag_in;   // s4 magnitude, sign
   logic [5:0]                    esgn_ff, esgn_in;
   logic [5:0][PROD_W-1:0]        prod_ff, prod_in;   // s5 products
   logic [5:0]                    psgn_ff, psgn_in;
   logic [5:0][SPROD_W-1:0]       sprod_ff, sprod_in; // s6 signed products
   logic [2:0][CROSS_W-1:0]       cross_ff, cross_in; // s7 cross product
   logic [2:0][CMAG_W-1:0]        cmag_ff, cmag_in;   // s8 magnitude
   logic [2:0]                    cneg_ff, cneg_in;
   logic [2:0][MM_W-1:0]          mm_ff, mm_in;       // s9 scaled magnitude
   logic [2:0]                    mneg_ff, mneg_in;
   logic [SHIFT_W-1:0]            shift_ff, shift_in;
   logic                          degen_ff, degen_in;
   logic [2:0][2*MM_HI_W-1:0]     phh_ff, phh_in;     // s10 partial squares
   logic [2:0][MM_HI_W+MM_LO_W-1:0] phl_ff, phl_in;
   logic [2:0][2*MM_LO_W-1:0]     pll_ff, pll_in;
   logic [2:0][MM_W-1:0]          mm2_ff, mm2_in;
   logic [2:0]                    mneg2_ff, mneg2_in;
   logic [SHIFT_W-1:0]            shift2_ff, shift2_in;
   logic                          degen2_ff, degen2_in;
   logic [2:0][SQ_W-1:0]          sq_ff, sq_in;       // s11 squares
   logic [2:0][MM_W-1:0]          mm3_ff, mm3_in;
   logic [2:0]                    mneg3_ff, mneg3_in;
   logic [SHIFT_W-1:0]            shift3_ff, shift3_in;
   logic                          degen3_ff, degen3_in;

   // square root stages: stage 0 holds the sum of squares
   sqrt_stage_type                rt_ff [0:SQRT_STEPS];
   sqrt_stage_type                rt_in [0:SQRT_STEPS];
   logic [SQRT_STEPS:0]           rt_vld_ff, rt_vld_in;

   // divider stages: stage 0 holds the leading quotient bit
   div_stage_type                 dv_ff [0:DIV_STEPS];
   div_stage_type                 dv_in [0:DIV_STEPS];
   logic [DIV_STEPS:0]            dv_vld_ff, dv_vld_in;

   // output register
   logic                          rsp_valid_ff;
   logic [2:0][NORM_W-1:0]        norm_ff, norm_in;
   logic [AREA_W-1:0]             area_ff, area_in;
   logic                          rdegen_ff, rdegen_in;

   logic [2:0][COORD_W-1:0]       pa;
   logic [5:0][COORD_W-1:0]       pb;

   assign en        = ~(rsp_valid_ff & rsp_stall);
   assign req_stall = ~en;
   assign csr_ready = 1'b1;

   assign pa = {req_p1_z, req_p1_y, req_p1_x};
   assign pb = {req_p3_z, req_p3_y, req_p3_x, req_p2_z, req_p2_y, req_p2_x};

   assign fv_in = {fv_ff[FRONT_STAGES-2:0], req_valid};

   // edges, minimum-image wrap, products, cross product
   always_comb begin
      logic [DIFF_W:0]  dbl;
      logic [DIFF_W:0]  boxe;
      logic [DIFF_W:0]  dext;
      logic [DIFF_W:0]  wsum;
      logic [CMAG_W-1:0] orall;
      for (int j = 0; j < 6; j++) begin
         diff_in[j] = DIFF_W'($signed(pb[j])) - DIFF_W'($signed(pa[j % 3]));

         // 2|d| > box, tested without taking the magnitude first
         dbl  = {diff_ff[j], 1'b0};
         boxe = (DIFF_W+1)'(box_ff[j % 3]);
         wsum = dbl + boxe;
         wrap_in[j] = diff_ff[j][DIFF_W-1] ? wsum[DIFF_W] : (dbl > boxe);
         dw_in[j]   = diff_ff[j];

         dext = {dw_ff[j][DIFF_W-1], dw_ff[j]};
         boxe = (DIFF_W+1)'(box_ff[j % 3]);
         if (!wrap_ff[j]) begin
            edge_in[j] = dw_ff[j];
         end else if (dw_ff[j][DIFF_W-1]) begin
            wsum       = dext + boxe;
            edge_in[j] = wsum[DIFF_W-1:0];
         end else begin
            wsum       = dext - boxe;
            edge_in[j] = wsum[DIFF_W-1:0];
         end

         // wrapped edges stay below 2^32 in magnitude
         esgn_in[j] = edge_ff[j][DIFF_W-1];
         emag_in[j] = edge_ff[j][DIFF_W-1] ? MAG_W'(-edge_ff[j]) : MAG_W'(edge_ff[j]);

         sprod_in[j] = psgn_ff[j] ? -{1'b0, prod_ff[j]} : {1'b0, prod_ff[j]};
      end

      // ay*bz, az*by, az*bx, ax*bz, ax*by, ay*bx
      prod_in[0] = PROD_W'(emag_ff[1]) * PROD_W'(emag_ff[5]);
      prod_in[1] = PROD_W'(emag_ff[2]) * PROD_W'(emag_ff[4]);
      prod_in[2] = PROD_W'(emag_ff[2]) * PROD_W'(emag_ff[3]);
      prod_in[3] = PROD_W'(emag_ff[0]) * PROD_W'(emag_ff[5]);
      prod_in[4] = PROD_W'(emag_ff[0]) * PROD_W'(emag_ff[4]);
      prod_in[5] = PROD_W'(emag_ff[1]) * PROD_W'(emag_ff[3]);
      psgn_in[0] = esgn_ff[1] ^ esgn_ff[5];
      psgn_in[1] = esgn_ff[2] ^ esgn_ff[4];
      psgn_in[2] = esgn_ff[2] ^ esgn_ff[3];
      psgn_in[3] = esgn_ff[0] ^ esgn_ff[5];
      psgn_in[4] = esgn_ff[0] ^ esgn_ff[4];
      psgn_in[5] = esgn_ff[1] ^ esgn_ff[3];

      for (int i = 0; i < 3; i++) begin
         cross_in[i] = {sprod_ff[2*i][SPROD_W-1], sprod_ff[2*i]}
                     - {sprod_ff[2*i+1][SPROD_W-1], sprod_ff[2*i+1]};
         cneg_in[i]  = cross_ff[i][CROSS_W-1];
         cmag_in[i]  = cross_ff[i][CROSS_W-1] ? CMAG_W'(-cross_ff[i])
                                               : CMAG_W'(cross_ff[i]);
      end

      // drop low bits so the largest magnitude fits in 61 bits
      orall = cmag_ff[0] | cmag_ff[1] | cmag_ff[2];
      if (orall[CMAG_W-1])      shift_in = SHIFT_W'(4);
      else if (orall[CMAG_W-2]) shift_in = SHIFT_W'(3);
      else if (orall[CMAG_W-3]) shift_in = SHIFT_W'(2);
      else if (orall[CMAG_W-4]) shift_in = SHIFT_W'(1);
      else                      shift_in = SHIFT_W'(0);
      degen_in = (orall == '0);
      mneg_in  = cneg_ff;
      for (int i = 0; i < 3; i++) begin
         mm_in[i] = MM_W'(cmag_ff[i] >> shift_in);
      end

      // squares from a 30-bit high half and a 31-bit low half
      for (int i = 0; i < 3; i++) begin
         phh_in[i] = (2*MM_HI_W)'(mm_ff[i][MM_W-1:MM_LO_W])
                   * (2*MM_HI_W)'(mm_ff[i][MM_W-1:MM_LO_W]);
         phl_in[i] = (MM_HI_W+MM_LO_W)'(mm_ff[i][MM_W-1:MM_LO_W])
                   * (MM_HI_W+MM_LO_W)'(mm_ff[i][MM_LO_W-1:0]);
         pll_in[i] = (2*MM_LO_W)'(mm_ff[i][MM_LO_W-1:0])
                   * (2*MM_LO_W)'(mm_ff[i][MM_LO_W-1:0]);
         sq_in[i]  = (SQ_W'(phh_ff[i]) << (2*MM_LO_W))
                   + (SQ_W'(phl_ff[i]) << (MM_LO_W+1))
                   + SQ_W'(pll_ff[i]);
      end
      mm2_in    = mm_ff;
      mneg2_in  = mneg_ff;
      shift2_in = shift_ff;
      degen2_in = degen_ff;
      mm3_in    = mm2_ff;
      mneg3_in  = mneg2_ff;
      shift3_in = shift2_ff;
      degen3_in = degen2_ff;
   end

   // sum of squares enters the root pipeline
   always_comb begin
      rt_in[0].rad   = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
      rt_in[0].root  = '0;
      rt_in[0].mm    = mm3_ff;
      rt_in[0].neg   = mneg3_ff;
      rt_in[0].shift = shift3_ff;
      rt_in[0].degen = degen3_ff;
   end
   assign rt_vld_in = {rt_vld_ff[SQRT_STEPS-1:0], fv_ff[FRONT_STAGES-1]};

   // restoring square root, one result bit per stage
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      localparam int BIT_POS = 2 * (SQRT_STEPS - 1 - k);
      always_comb begin
         logic [SUM_W-1:0] bitv;
         logic [SUM_W-1:0] trial;
         bitv  = SUM_W'(1) << BIT_POS;
         trial = rt_ff[k].root + bitv;
         rt_in[k+1] = rt_ff[k];
         if (rt_ff[k].rad >= trial) begin
            rt_in[k+1].rad  = rt_ff[k].rad - trial;
            rt_in[k+1].root = (rt_ff[k].root >> 1) + bitv;
         end else begin
            rt_in[k+1].root = rt_ff[k].root >> 1;
         end
      end
   end

   // leading quotient bit and area
   always_comb begin
      logic [ROOT_W-1:0]  r;
      logic [4:0]         ash;
      logic [ROOT_W-1:0]  ashifted;
      logic               ge;
      r   = rt_ff[SQRT_STEPS].root[ROOT_W-1:0];
      ash = 5'(FRAC_BITS + 1) - 5'(rt_ff[SQRT_STEPS].shift);
      ashifted = r >> ash;
      dv_in[0].den   = r;
      dv_in[0].neg   = rt_ff[SQRT_STEPS].neg;
      dv_in[0].degen = rt_ff[SQRT_STEPS].degen;
      dv_in[0].area  = (ashifted[ROOT_W-1:AREA_W] != '0) ? {AREA_W{1'b1}}
                                                          : ashifted[AREA_W-1:0];
      for (int i = 0; i < 3; i++) begin
         ge = (REM_W'(rt_ff[SQRT_STEPS].mm[i]) >= r);
         dv_in[0].rem[i]  = ge ? REM_W'(rt_ff[SQRT_STEPS].mm[i]) - r
                               : REM_W'(rt_ff[SQRT_STEPS].mm[i]);
         dv_in[0].quot[i] = QUOT_W'(ge);
      end
   end
   assign dv_vld_in = {dv_vld_ff[DIV_STEPS-1:0], rt_vld_ff[SQRT_STEPS]};

   // three restoring dividers side by side, one quotient bit per stage
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      always_comb begin
         logic [REM_W:0] shl;
         logic [REM_W:0] diffv;
         logic           ge;
         dv_in[k+1] = dv_ff[k];
         for (int i = 0; i < 3; i++) begin
            shl   = {dv_ff[k].rem[i], 1'b0};
            diffv = shl - {1'b0, dv_ff[k].den};
            ge    = (shl >= {1'b0, dv_ff[k].den});
            dv_in[k+1].rem[i]  = ge ? diffv[REM_W-1:0] : shl[REM_W-1:0];
            dv_in[k+1].quot[i] = {dv_ff[k].quot[i][QUOT_W-2:0], ge};
         end
      end
   end

   // sign and degenerate masking
   always_comb begin
      logic [NORM_W-1:0] q;
      for (int i = 0; i < 3; i++) begin
         q = NORM_W'(dv_ff[DIV_STEPS].quot[i]);
         if (dv_ff[DIV_STEPS].degen)    norm_in[i] = '0;
         else if (dv_ff[DIV_STEPS].neg[i]) norm_in[i] = -q;
         else                           norm_in[i] = q;
      end
      area_in   = dv_ff[DIV_STEPS].degen ? '0 : dv_ff[DIV_STEPS].area;
      rdegen_in = dv_ff[DIV_STEPS].degen;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff       <= {BOX_RESET, BOX_RESET, BOX_RESET};
         fv_ff        <= '0;
         rt_vld_ff    <= '0;
         dv_vld_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               REG_BOX_X: box_ff[0] <= csr_wdata;
               REG_BOX_Y: box_ff[1] <= csr_wdata;
               REG_BOX_Z: box_ff[2] <= csr_wdata;
               default: ;
            endcase
         end
         if (en) begin
            fv_ff        <= fv_in;
            rt_vld_ff    <= rt_vld_in;
            dv_vld_ff    <= dv_vld_in;
            rsp_valid_ff <= dv_vld_ff[DIV_STEPS];
         end
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      if (en) begin
         diff_ff   <= diff_in;
         dw_ff     <= dw_in;
         wrap_ff   <= wrap_in;
         edge_ff   <= edge_in;
         emag_ff   <= emag_in;
         esgn_ff   <= esgn_in;
         prod_ff   <= prod_in;
         psgn_ff   <= psgn_in;
         sprod_ff  <= sprod_in;
         cross_ff  <= cross_in;
         cmag_ff   <= cmag_in;
         cneg_ff   <= cneg_in;
         mm_ff     <= mm_in;
         mneg_ff   <= mneg_in;
         shift_ff  <= shift_in;
         degen_ff  <= degen_in;
         phh_ff    <= phh_in;
         phl_ff    <= phl_in;
         pll_ff    <= pll_in;
         mm2_ff    <= mm2_in;
         mneg2_ff  <= mneg2_in;
         shift2_ff <= shift2_in;
         degen2_ff <= degen2_in;
         sq_ff     <= sq_in;
         mm3_ff    <= mm3_in;
         mneg3_ff  <= mneg3_in;
         shift3_ff <= shift3_in;
         degen3_ff <= degen3_in;
         rt_ff     <= rt_in;
         dv_ff     <= dv_in;
         norm_ff   <= norm_in;
         area_ff   <= area_in;
         rdegen_ff <= rdegen_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_normal_x   = norm_ff[0];
   assign rsp_normal_y   = norm_ff[1];
   assign rsp_normal_z   = norm_ff[2];
   assign rsp_tri_area   = area_ff;
   assign rsp_degenerate = rdegen_ff;

endmodule

// File: test/tb_periodic_triangle_normal_area.sv
module tb_periodic_triangle_normal_area;
   timeunit 1ns;
   timeprecision 1ps;

   import ptna_pkg::*;

   // index past box_z, the block drops writes to it
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;
   localparam logic [BOX_W-1:0] BOX_MAX = '1;
   // front + sqrt + divider + output register, with slack
   localparam int PIPE_DRAIN = 120;

   typedef struct packed {
      logic signed [NORM_W-1:0] nx;
      logic signed [NORM_W-1:0] ny;
      logic signed [NORM_W-1:0] nz;
      logic [AREA_W-1:0]        area;
      logic                     degen;
   } facet_type;

   // predicts normal/area per triangle and holds the results still owed by the block
   class facet_scoreboard;
      logic [BOX_W-1:0] box[3];
      facet_type        owed[$];
      int               mismatches;

      function new();
         box = '{BOX_RESET, BOX_RESET, BOX_RESET};
         mismatches = 0;
      endfunction

      function void set_box(logic [CSR_IDX_W-1:0] idx, logic [BOX_W-1:0] val);
         if (idx == REG_BOX_X) box[0] = val;
         else if (idx == REG_BOX_Y) box[1] = val;
         else if (idx == REG_BOX_Z) box[2] = val;
      endfunction

      function facet_type facet_of(logic signed [COORD_W-1:0] v[9]);
         facet_type          f;
         longint             d, mg;
         logic signed [127:0] e[6];
         logic signed [127:0] c[3];
         logic [127:0]       m[3], all, sum, mm, q;
         logic [63:0]        r, t;
         int                 len, s, sh;
         logic [127:0]       ar;
         for (int k = 0; k < 6; k++) begin
            d = longint'(v[3 + k]) - longint'(v[k % 3]);
            mg = (d < 0) ? -d : d;
            // minimum image fold
            if (2 * mg > longint'(box[k % 3]))
               d = (d < 0) ? d + longint'(box[k % 3]) : d - longint'(box[k % 3]);
            e[k] = d;
         end
         c[0] = e[1] * e[5] - e[2] * e[4];
         c[1] = e[2] * e[3] - e[0] * e[5];
         c[2] = e[0] * e[4] - e[1] * e[3];
         all = '0;
         for (int i = 0; i < 3; i++) begin
            m[i] = (c[i] < 0) ? -c[i] : c[i];
            all |= m[i];
         end
         f = '0;
         if (all == 0) begin
            f.degen = 1'b1;
            return f;
         end
         len = 0;
         for (int b = 0; b < 128; b++) if (all[b]) len = b + 1;
         s = (len > 61) ? len - 61 : 0;
         sum = '0;
         for (int i = 0; i < 3; i++) begin
            mm = m[i] >> s;
            sum += mm * mm;
         end
         r = '0;
         for (int b = 63; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (128'(t) * 128'(t) <= sum) r = t;
         end
         for (int i = 0; i < 3; i++) begin
            q = ((m[i] >> s) << 30) / 128'(r);
            if (c[i] < 0) q = -q;
            if (i == 0) f.nx = q[31:0];
            else if (i == 1) f.ny = q[31:0];
            else f.nz = q[31:0];
         end
         if (s >= FRAC_BITS + 1) begin
            sh = s - (FRAC_BITS + 1);
            if (sh >= 48 || (r >> (48 - sh)) != 0) ar = {80'd0, {AREA_W{1'b1}}};
            else ar = 128'(r) << sh;
         end else begin
            ar = 128'(r) >> (FRAC_BITS + 1 - s);
         end
         if (ar > {80'd0, {AREA_W{1'b1}}}) ar = {80'd0, {AREA_W{1'b1}}};
         f.area = ar[AREA_W-1:0];
         return f;
      endfunction

      function void note_triangle(logic signed [COORD_W-1:0] v[9]);
         owed.push_back(facet_of(v));
      endfunction

      function void check_facet(facet_type got);
         facet_type want;
         if (owed.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", got);
            return;
         end
         want = owed.pop_front();
         if (got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz
             || got.area !== want.area || got.degen !== want.degen) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch: exp n=(%0d %0d %0d) area=%h degen=%b,",
                         " got n=(%0d %0d %0d) area=%h degen=%b"},
                        want.nx, want.ny, want.nz, want.area, want.degen,
                        got.nx, got.ny, got.nz, got.area, got.degen);
         end
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic signed [COORD_W-1:0] crd[9] = '{default: '0};
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [NORM_W-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic [AREA_W-1:0]       rsp_tri_area;
   logic                    rsp_degenerate;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [BOX_W-1:0]        csr_wdata = '0;

   facet_scoreboard sb = new();
   int burst_left = 0;
   int stall_mode = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   periodic_triangle_normal_area i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_p1_x(crd[0]), .req_p1_y(crd[1]), .req_p1_z(crd[2]),
      .req_p2_x(crd[3]), .req_p2_y(crd[4]), .req_p2_z(crd[5]),
      .req_p3_x(crd[6]), .req_p3_y(crd[7]), .req_p3_z(crd[8]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_normal_x(rsp_normal_x), .rsp_normal_y(rsp_normal_y),
      .rsp_normal_z(rsp_normal_z), .rsp_tri_area(rsp_tri_area),
      .rsp_degenerate(rsp_degenerate),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // result side: check every accepted beat against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_facet('{rsp_normal_x, rsp_normal_y, rsp_normal_z, rsp_tri_area,
                          rsp_degenerate});
   end

   // receiver back-pressure: free-flowing, light random, or heavy stall stretches
   always @(negedge clock) begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 9) != 0);
      endcase
   end

   task automatic write_box(logic [CSR_IDX_W-1:0] idx, logic [BOX_W-1:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      do @(posedge clock); while (!csr_ready);
      sb.set_box(idx, val);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // one triangle beat; the sender runs in bursts with random gaps between them
   task automatic send_triangle(logic signed [COORD_W-1:0] v[9]);
      @(negedge clock);
      if (burst_left == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
      crd = v;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_triangle(v);
      burst_left--;
   endtask

   task automatic drain_pipe();
      @(negedge clock);
      req_valid = 1'b0;
      burst_left = 0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   // edge component biased toward the interesting spots: small, near half box, near a full box, anything
   function automatic logic signed [COORD_W-1:0] pick_delta(int axis);
      longint hb;
      hb = longint'(sb.box[axis]) / 2;
      case ($urandom_range(0, 5))
         0, 1: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
         2: return COORD_W'(hb + $signed($urandom_range(0, 4)) - 2);
         3: return COORD_W'(-hb + $signed($urandom_range(0, 4)) - 2);
         4: return COORD_W'(longint'(sb.box[axis]) * ($urandom_range(0, 1) ? 1 : -1)
                             + $signed($urandom_range(0, 64)) - 32);
         default: return $urandom;
      endcase
   endfunction

   task automatic random_triangle();
      logic signed [COORD_W-1:0] v[9];
      int k;
      int kind;
      kind = $urandom_range(0, 9);
      for (int a = 0; a < 3; a++) v[a] = $urandom;
      for (int a = 0; a < 3; a++) begin
         v[3 + a] = v[a] + pick_delta(a);
         v[6 + a] = v[a] + pick_delta(a);
      end
      if (kind == 0) begin
         // collinear edges, usually a zero cross product
         k = $signed($urandom_range(0, 6)) - 3;
         for (int a = 0; a < 3; a++) begin
            v[3 + a] = v[a] + ($signed($urandom_range(0, 1 << 12)) - (1 << 11));
            v[6 + a] = v[a] + k * (v[3 + a] - v[a]);
         end
      end else if (kind == 1) begin
         for (int a = 0; a < 9; a++) v[a] = $urandom;
      end
      send_triangle(v);
   endtask

   task automatic directed_triangles();
      logic signed [COORD_W-1:0] mx, mn;
      mx = {1'b0, {(COORD_W-1){1'b1}}};
      mn = {1'b1, {(COORD_W-1){1'b0}}};
      send_triangle('{default: '0});
      send_triangle('{default: mx});
      send_triangle('{default: mn});
      send_triangle('{mn, mn, mn, mx, mn, mn, mn, mx, mn});
      send_triangle('{mx, mx, mx, mn, mx, mx, mx, mn, mx});
      send_triangle('{mn, mx, mn, mx, mn, mx, mn, mn, mx});
      send_triangle('{0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0});
      send_triangle('{0, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000});
      send_triangle('{0, 0, 0, 32'h50000, 0, 0, 0, 32'h50000, 0});
      send_triangle('{0, 0, 0, 32'h50001, 0, 0, 0, -32'sh50001, 0});
      send_triangle('{1, 2, 3, 3, 6, 9, 5, 10, 15});
      send_triangle('{0, 0, 0, 1, 0, 0, 0, 1, 0});
      send_triangle('{-1, -1, -1, -1, -1, -1, 7, 8, 9});
      send_triangle('{32'h7FFF0000, 0, 0, -32'sh7FFF0000, 32'h12345, 0, 0, 0, 32'h54321});
      send_triangle('{32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA,
                      32'h55555555, 32'hAAAAAAAA, 32'h55555555,
                      32'hFFFFFFFF, 32'h00000000, 32'h7FFFFFFF});
   endtask

   task automatic random_phase(int count);
      for (int n = 0; n < count; n++) begin
         random_triangle();
         // halfway through, the sender may hold off once until the pipe has drained
         if (n == count / 2 && $urandom_range(0, 1)) begin
            @(negedge clock);
            req_valid = 1'b0;
            burst_left = 0;
            while (sb.owed.size() != 0) @(posedge clock);
         end
      end
      drain_pipe();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset box sides first
      directed_triangles();
      random_phase(300);

      // widest box: only edges longer than half of it wrap
      write_box(REG_BOX_X, BOX_MAX);
      write_box(REG_BOX_Y, BOX_MAX);
      write_box(REG_BOX_Z, BOX_MAX);
      write_box(REG_UNUSED, '0);
      directed_triangles();
      random_phase(300);

      // unit and zero sides: every edge wraps, or wrap adds nothing
      write_box(REG_BOX_X, 31'd1);
      write_box(REG_BOX_Y, 31'd0);
      write_box(REG_BOX_Z, 31'd1);
      write_box(REG_UNUSED, BOX_MAX);
      directed_triangles();
      random_phase(250);

      for (int p = 0; p < 4; p++) begin
         write_box(REG_BOX_X, BOX_W'($urandom_range(1, 1 << 24)));
         write_box(REG_BOX_Y, BOX_W'($urandom));
         write_box(REG_BOX_Z, BOX_W'($urandom_range(1, 1 << 20)));
         random_phase(280);
      end

      write_box(REG_BOX_X, 31'h40000000);
      write_box(REG_BOX_Y, BOX_MAX);
      write_box(REG_BOX_Z, 31'd2);
      random_phase(100);

      repeat (PIPE_DRAIN) @(posedge clock);
      if (sb.mismatches == 0 && sb.owed.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("tb: failure");
      $finish;
   end

endmodule
